@@ rtl/eed_pkg.sv @@
`default_nettype none

package eed_pkg;

  // Character codes used by the decoder
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_BELL      = 8'h07;
  localparam logic [7:0] CHAR_BSPACE    = 8'h08;
  localparam logic [7:0] CHAR_FFEED     = 8'h0C;
  localparam logic [7:0] CHAR_VTAB      = 8'h0B;
  localparam logic [7:0] CHAR_ESC       = 8'h1B;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_SEVEN     = 8'h37;

  // Escape letters
  localparam logic [7:0] LTR_N = 8'h6E;
  localparam logic [7:0] LTR_T = 8'h74;
  localparam logic [7:0] LTR_R = 8'h72;
  localparam logic [7:0] LTR_A = 8'h61;
  localparam logic [7:0] LTR_B = 8'h62;
  localparam logic [7:0] LTR_F = 8'h66;
  localparam logic [7:0] LTR_V = 8'h76;
  localparam logic [7:0] LTR_E = 8'h65;
  localparam logic [7:0] LTR_C = 8'h63;

  localparam logic [1:0] OCTAL_MAX_DIGITS = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_INTERPRET = 2'd0;
  localparam logic [1:0] CFG_SUPPRESS  = 2'd1;

  typedef enum logic [1:0] {
    OP_CHAR = 2'd0,
    OP_SEP  = 2'd1,
    OP_EOL  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_OCTAL  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/eed_if.sv @@
`default_nettype none

// Input event channel
interface eed_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] char_in;

  modport source (output valid, output opcode, output char_in, input ready);
  modport sink   (input valid, input opcode, input char_in, output ready);
endinterface

// Output byte channel
interface eed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// Configuration write channel
interface eed_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/echo_escape_decoder.sv @@
// Escape decoder for the output stage of an echo command.
// in_i   : one event word per handshake: opcode 0 is an argument byte (char_in),
//          1 an argument separator, 2 end of line; opcode 3 is dropped.
// out_o  : emitted bytes; last_of_run marks the final byte caused by one event.
//          An event gives zero, one or two bytes.
// cfg_i  : register writes, always ready. Index 0 enables escape decoding,
//          index 1 suppresses the trailing newline. Other indexes are ignored.
//          Write only while the block is idle.
// Output: accepted bytes go into the result queue and reach out_o in order.
// Throughput: one event per cycle while each event gives at most one byte
//          and out_o is ready; a two-byte event sends its bytes in turn. The limit is
//          the single output port draining a 4-word result queue.
// Stalls: in_i.ready drops when the queue has fewer than two free words, so a
//          stalled receiver backs up into the sender without loss; an event is
//          accepted while earlier bytes still wait in the queue.
// Reset: queue emptied, decoder back to normal text, both registers cleared.
`default_nettype none

module echo_escape_decoder
  import eed_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  eed_in_if.sink     in_i,
  eed_out_if.source  out_o,
  eed_cfg_if.sink    cfg_i
);

  localparam int QDEPTH = 4;
  localparam int PW     = $clog2(QDEPTH);

  // Config registers
  logic interp_q, supp_q;

  // Decoder state
  mode_e       mode_q, mode_d;
  logic [8:0]  oval_q, oval_d;
  logic [1:0]  ocnt_q, ocnt_d;
  logic        stop_q, stop_d;

  // Result queue
  res_t          q_mem [QDEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PW:0]   cnt_q, cnt_d;

  logic       in_acc, out_acc;
  logic [1:0] n_res;
  logic [7:0] res_b [2];

  // Combinational decode of one event
  logic       has_pend;
  logic [7:0] pend_b;
  logic       is_oct;
  logic [8:0] oval_nx;
  logic [1:0] ocnt_nx;
  logic       do_norm;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  assign in_i.ready = (cnt_q <= (PW+1)'(QDEPTH - 2));
  assign cfg_i.ready = 1'b1;

  assign has_pend = (mode_q != MODE_NORMAL);
  assign pend_b   = (mode_q == MODE_ESCAPE) ? CHAR_BACKSLASH : oval_q[7:0];
  assign is_oct   = (in_i.char_in >= CHAR_ZERO) && (in_i.char_in <= CHAR_SEVEN);
  assign oval_nx  = {oval_q[5:0], in_i.char_in[2:0]};
  assign ocnt_nx  = ocnt_q + 2'd1;

  always_comb begin
    mode_d   = mode_q;
    oval_d   = oval_q;
    ocnt_d   = ocnt_q;
    stop_d   = stop_q;
    n_res    = 2'd0;
    res_b[0] = CHAR_SPACE;
    res_b[1] = CHAR_SPACE;
    do_norm  = 1'b0;

    case (op_e'(in_i.opcode))
      OP_CHAR: begin
        if (!stop_q) begin
          if (!interp_q) begin
            // Flush any pending sequence, then pass the byte
            if (has_pend) begin
              res_b[0] = pend_b;
              res_b[1] = in_i.char_in;
              n_res    = 2'd2;
            end else begin
              res_b[0] = in_i.char_in;
              n_res    = 2'd1;
            end
            mode_d = MODE_NORMAL;
            oval_d = '0;
            ocnt_d = '0;
          end else begin
            unique case (mode_q)
              MODE_ESCAPE: begin
                mode_d = MODE_NORMAL;
                n_res  = 2'd1;
                unique case (in_i.char_in)
                  LTR_N:          res_b[0] = CHAR_NEWLINE;
                  LTR_T:          res_b[0] = CHAR_TAB;
                  LTR_R:          res_b[0] = CHAR_CR;
                  LTR_A:          res_b[0] = CHAR_BELL;
                  LTR_B:          res_b[0] = CHAR_BSPACE;
                  LTR_F:          res_b[0] = CHAR_FFEED;
                  LTR_V:          res_b[0] = CHAR_VTAB;
                  LTR_E:          res_b[0] = CHAR_ESC;
                  CHAR_BACKSLASH: res_b[0] = CHAR_BACKSLASH;
                  LTR_C: begin
                    stop_d = 1'b1;
                    n_res  = 2'd0;
                  end
                  CHAR_ZERO: begin
                    mode_d = MODE_OCTAL;
                    oval_d = '0;
                    ocnt_d = '0;
                    n_res  = 2'd0;
                  end
                  default: begin
                    // unknown escape: backslash and the byte itself
                    res_b[0] = CHAR_BACKSLASH;
                    res_b[1] = in_i.char_in;
                    n_res    = 2'd2;
                  end
                endcase
              end
              MODE_OCTAL: begin
                if (is_oct) begin
                  if (ocnt_nx >= OCTAL_MAX_DIGITS) begin
                    res_b[0] = oval_nx[7:0];
                    n_res    = 2'd1;
                    mode_d   = MODE_NORMAL;
                    oval_d   = '0;
                    ocnt_d   = '0;
                  end else begin
                    oval_d = oval_nx;
                    ocnt_d = ocnt_nx;
                  end
                end else begin
                  res_b[0] = oval_q[7:0];
                  n_res    = 2'd1;
                  mode_d   = MODE_NORMAL;
                  oval_d   = '0;
                  ocnt_d   = '0;
                  do_norm  = 1'b1;
                end
              end
              default: do_norm = 1'b1;
            endcase

            // Normal text handling, after a possible octal flush
            if (do_norm) begin
              if (in_i.char_in == CHAR_BACKSLASH) begin
                mode_d = MODE_ESCAPE;
              end else begin
                res_b[n_res[0]] = in_i.char_in;
                n_res           = n_res + 2'd1;
              end
            end
          end
        end
      end
      OP_SEP: begin
        if (!stop_q) begin
          if (has_pend) begin
            res_b[0] = pend_b;
            res_b[1] = CHAR_SPACE;
            n_res    = 2'd2;
          end else begin
            res_b[0] = CHAR_SPACE;
            n_res    = 2'd1;
          end
          mode_d = MODE_NORMAL;
          oval_d = '0;
          ocnt_d = '0;
        end
      end
      OP_EOL: begin
        if (!stop_q) begin
          if (has_pend) begin
            res_b[0] = pend_b;
            n_res    = 2'd1;
          end
          if (!supp_q) begin
            res_b[n_res[0]] = CHAR_NEWLINE;
            n_res           = n_res + 2'd1;
          end
        end
        mode_d = MODE_NORMAL;
        oval_d = '0;
        ocnt_d = '0;
        stop_d = 1'b0;
      end
      default: ; // unused opcode: no output, no state change
    endcase
  end

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interp_q <= 1'b0;
      supp_q   <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      if (cfg_i.index == CFG_INTERPRET) interp_q <= cfg_i.data;
      if (cfg_i.index == CFG_SUPPRESS)  supp_q   <= cfg_i.data;
    end
  end

  // Decoder state, updated per accepted event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      oval_q <= '0;
      ocnt_q <= '0;
      stop_q <= 1'b0;
    end else if (in_acc) begin
      mode_q <= mode_d;
      oval_q <= oval_d;
      ocnt_q <= ocnt_d;
      stop_q <= stop_d;
    end
  end

  // Result queue storage
  always_ff @(posedge clk_i) begin
    if (in_acc && (n_res != 2'd0)) begin
      q_mem[wr_ptr_q] <= '{data: res_b[0], last: (n_res == 2'd1)};
    end
    if (in_acc && (n_res == 2'd2)) begin
      q_mem[wr_ptr_q + PW'(1)] <= '{data: res_b[1], last: 1'b1};
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc)  cnt_d = cnt_d + (PW+1)'(n_res);
    if (out_acc) cnt_d = cnt_d - (PW+1)'(1);
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (in_acc)  wr_ptr_q <= wr_ptr_q + PW'(n_res);
      if (out_acc) rd_ptr_q <= rd_ptr_q + PW'(1);
    end
  end

  assign out_o.valid       = (cnt_q != '0);
  assign out_o.out_byte    = q_mem[rd_ptr_q].data;
  assign out_o.last_of_run = q_mem[rd_ptr_q].last;

endmodule

`default_nettype wire
